/* rtl/egsc_pkg.sv */
package egsc_pkg;

   // graph size and adjacency storage
   localparam int VERTICES   = 256;
   localparam int WORD_BITS  = 64;
   localparam int ROW_WORDS  = (VERTICES + WORD_BITS - 1) / WORD_BITS;
   localparam int MEM_DEPTH  = VERTICES * ROW_WORDS;
   localparam int ADDR_W     = $clog2(MEM_DEPTH);
   localparam int WORD_W     = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
   localparam int SCAN_READS = 2 * ROW_WORDS;
   localparam int IDX_W      = $clog2(SCAN_READS);

   // field widths
   localparam int VTX_W    = 8;
   localparam int STATUS_W = 2;
   localparam int SUP_W    = 8;
   localparam int EDGE_W   = 15;
   localparam int VCNT_W   = 9;
   localparam int RSP_W    = 40;

   // item kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SELF  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DUP   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   typedef logic [WORD_BITS-1:0] word_type;

   // RAM address of word k of a vertex's row
   function automatic logic [ADDR_W-1:0] word_addr(logic [VTX_W-1:0] vtx,
                                                   logic [WORD_W-1:0] k);
      return ADDR_W'(32'(vtx) * 32'(ROW_WORDS) + 32'(k));
   endfunction

   function automatic logic in_range(logic [VTX_W-1:0] vtx);
      return 32'(vtx) < 32'(VERTICES);
   endfunction

   // SWAR population count of one 64-bit word
   function automatic logic [6:0] popcount64(word_type x);
      word_type s1;
      word_type s2;
      word_type s3;
      word_type s4;
      word_type s5;
      word_type s6;
      s1 = x - ((x >> 1) & 64'h5555_5555_5555_5555);
      s2 = (s1 & 64'h3333_3333_3333_3333) + ((s1 >> 2) & 64'h3333_3333_3333_3333);
      s3 = (s2 + (s2 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
      s4 = s3 + (s3 >> 8);
      s5 = s4 + (s4 >> 16);
      s6 = s5 + (s5 >> 32);
      return s6[6:0];
   endfunction

endpackage

/* rtl/graph_edge_support_counter_top.sv */
// Query or duplicate insert: a scan of 2*ROW_WORDS reads through the single RAM read port,
//   row u and row v words in turn, then the result; only one item is in flight at a time.
// New edge insert: the scan is followed by the two adjacency write-backs, row u then row v.
// Self loop or out-of-range item: no scan; S_FINISH loads the result once the response register is free.
// Reset (synchronous, active high) clears control state and counters, then a clearing
//   pass writes zero to all VERTICES*ROW_WORDS words (1024) of the matrix; req_tready stays low.
module graph_edge_support_counter_top
   import egsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,  // [7:0] first_vertex, [15:8] second_vertex
   input  logic             req_tuser,  // [0] kind (0 insert, 1 query)
   // response channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // [1:0] insert_status, [2] edge_present,
                                        // [10:3] support, [25:11] edge_count,
                                        // [34:26] vertex_count, [39:35] zero
);

   // sequencer states
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_WR_U   = 3'd3;
   localparam logic [2:0] S_WR_V   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   localparam logic [IDX_W:0]   ISS_END  = (IDX_W + 1)'(SCAN_READS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SCAN_READS - 1);
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MEM_DEPTH - 1);

   // control
   logic [2:0]        state_ff,        state_in;
   logic [ADDR_W-1:0] clr_addr_ff,     clr_addr_in;
   logic [IDX_W:0]    iss_ff,          iss_in;
   logic              rd_valid_ff,     rd_valid_in;
   logic [IDX_W-1:0]  rd_idx_ff,       rd_idx_in;
   logic              rsp_valid_ff,    rsp_valid_in;
   logic [EDGE_W-1:0] edge_total_ff,   edge_total_in;
   logic [VCNT_W-1:0] vertex_total_ff, vertex_total_in;

   // item payload and scan results
   logic              kind_ff,   kind_in;
   logic [VTX_W-1:0]  u_ff,      u_in;
   logic [VTX_W-1:0]  v_ff,      v_in;
   logic              bad_ff,    bad_in;     // a vertex out of range
   logic              self_ff,   self_in;    // both ends equal
   word_type          word_u_ff, word_u_in;  // row u word waiting for its row v partner
   word_type          u_hit_ff,  u_hit_in;   // row u word that holds bit v
   word_type          v_hit_ff,  v_hit_in;   // row v word that holds bit u
   logic              edge_bit_ff, edge_bit_in;
   logic              u_any_ff,  u_any_in;   // row u has any neighbor
   logic              v_any_ff,  v_any_in;
   logic [SUP_W-1:0]  acc_ff,    acc_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   // RAM ports
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   word_type          ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   word_type          ram_rd_data;

   // decode
   logic              accept;
   logic              issue;
   logic [WORD_W-1:0] iss_k;
   logic [WORD_W-1:0] ret_k;
   logic [WORD_W-1:0] u_word;
   logic [WORD_W-1:0] v_word;
   logic              scan_done;
   logic              load;
   logic              new_edge;
   logic              present;
   logic [STATUS_W-1:0] status;
   logic [SUP_W-1:0]  support;
   logic [EDGE_W-1:0] edge_next;
   logic [VCNT_W-1:0] vertex_next;

   egsc_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign u_word = WORD_W'(u_ff >> 6);
   assign v_word = WORD_W'(v_ff >> 6);

   // read issue: even reads fetch row u word k, odd reads row v word k
   assign issue       = (state_ff == S_SCAN) && (iss_ff < ISS_END);
   assign iss_k       = WORD_W'(iss_ff[IDX_W-1:0] >> 1);
   assign ram_rd_en   = issue;
   assign ram_rd_addr = iss_ff[0] ? word_addr(v_ff, iss_k) : word_addr(u_ff, iss_k);

   assign ret_k     = WORD_W'(rd_idx_ff >> 1);
   assign scan_done = rd_valid_ff && (rd_idx_ff == IDX_LAST);

   // write port: clearing pass, then the two halves of a new edge
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_addr_ff;
      ram_wr_data = '0;
      case (state_ff)
         S_CLEAR: begin
            ram_wr_en = 1'b1;
         end
         S_WR_U: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = word_addr(u_ff, v_word);
            ram_wr_data = u_hit_ff | (word_type'(1) << v_ff[5:0]);
         end
         S_WR_V: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = word_addr(v_ff, u_word);
            ram_wr_data = v_hit_ff | (word_type'(1) << u_ff[5:0]);
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   // result; setting bit v in row u and bit u in row v leaves the AND of the
   // two rows unchanged, so the pre-insert count is the post-insert support
   assign load     = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign new_edge = (kind_ff == KIND_INSERT) && !bad_ff && !self_ff && !edge_bit_ff;
   assign present  = !bad_ff && !self_ff && (edge_bit_ff || new_edge);
   assign support  = present ? acc_ff : '0;

   always_comb begin
      if (bad_ff) begin
         status = (kind_ff == KIND_INSERT) ? ST_RANGE : ST_ADDED;
      end else if (self_ff) begin
         status = (kind_ff == KIND_INSERT) ? ST_SELF : ST_ADDED;
      end else if ((kind_ff == KIND_INSERT) && edge_bit_ff) begin
         status = ST_DUP;
      end else begin
         status = ST_ADDED;
      end
   end

   // a vertex is new exactly when its row was empty before the insert
   assign edge_next   = edge_total_ff + EDGE_W'(new_edge);
   assign vertex_next = vertex_total_ff + VCNT_W'(new_edge && !u_any_ff)
                                        + VCNT_W'(new_edge && !v_any_ff);

   always_comb begin
      state_in        = state_ff;
      clr_addr_in     = clr_addr_ff;
      iss_in          = iss_ff;
      rd_valid_in     = issue;
      rd_idx_in       = issue ? iss_ff[IDX_W-1:0] : rd_idx_ff;
      rsp_valid_in    = rsp_valid_ff;
      edge_total_in   = edge_total_ff;
      vertex_total_in = vertex_total_ff;
      kind_in         = kind_ff;
      u_in            = u_ff;
      v_in            = v_ff;
      bad_in          = bad_ff;
      self_in         = self_ff;
      word_u_in       = word_u_ff;
      u_hit_in        = u_hit_ff;
      v_hit_in        = v_hit_ff;
      edge_bit_in     = edge_bit_ff;
      u_any_in        = u_any_ff;
      v_any_in        = v_any_ff;
      acc_in          = acc_ff;
      rsp_data_in     = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               kind_in     = req_tuser;
               u_in        = req_tdata[7:0];
               v_in        = req_tdata[15:8];
               bad_in      = !in_range(req_tdata[7:0]) || !in_range(req_tdata[15:8]);
               self_in     = (req_tdata[7:0] == req_tdata[15:8]);
               iss_in      = '0;
               edge_bit_in = 1'b0;
               u_any_in    = 1'b0;
               v_any_in    = 1'b0;
               acc_in      = '0;
               if (bad_in || self_in) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (issue) begin
               iss_in = iss_ff + (IDX_W + 1)'(1);
            end
            if (rd_valid_ff) begin
               if (!rd_idx_ff[0]) begin
                  word_u_in = ram_rd_data;
                  u_any_in  = u_any_ff || (ram_rd_data != '0);
                  if (ret_k == v_word) begin
                     u_hit_in    = ram_rd_data;
                     edge_bit_in = ram_rd_data[v_ff[5:0]];
                  end
               end else begin
                  acc_in   = acc_ff + SUP_W'(popcount64(word_u_ff & ram_rd_data));
                  v_any_in = v_any_ff || (ram_rd_data != '0);
                  if (ret_k == u_word) begin
                     v_hit_in = ram_rd_data;
                  end
               end
            end
            if (scan_done) begin
               // edge bit is final: the last return is a row v word
               if ((kind_ff == KIND_INSERT) && !edge_bit_ff) begin
                  state_in = S_WR_U;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_WR_U: begin
            state_in = S_WR_V;
         end
         S_WR_V: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (load) begin
               rsp_valid_in    = 1'b1;
               rsp_data_in     = {5'd0, vertex_next, edge_next, support, present, status};
               edge_total_in   = edge_next;
               vertex_total_in = vertex_next;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_addr_ff     <= '0;
         iss_ff          <= '0;
         rd_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         edge_total_ff   <= '0;
         vertex_total_ff <= '0;
      end else begin
         state_ff        <= state_in;
         clr_addr_ff     <= clr_addr_in;
         iss_ff          <= iss_in;
         rd_valid_ff     <= rd_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         edge_total_ff   <= edge_total_in;
         vertex_total_ff <= vertex_total_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      kind_ff     <= kind_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      bad_ff      <= bad_in;
      self_ff     <= self_in;
      word_u_ff   <= word_u_in;
      u_hit_ff    <= u_hit_in;
      v_hit_ff    <= v_hit_in;
      edge_bit_ff <= edge_bit_in;
      u_any_ff    <= u_any_in;
      v_any_ff    <= v_any_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // one item in flight: the request side closes right after a transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted while an item is in progress");

   // the edge count only ever steps by one
   a_edge_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (edge_total_ff != $past(edge_total_ff)))
         |-> (edge_total_ff == $past(edge_total_ff) + EDGE_W'(1)))
      else $error("edge count changed by more than one");

   // each edge brings at most two new vertices
   a_vertex_bound: assert property (@(posedge clock) disable iff (reset)
      {7'd0, vertex_total_ff} <= {edge_total_ff, 1'b0})
      else $error("vertex count exceeds twice the edge count");

   // a duplicate insert always reports the edge as present
   a_dup_present: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] == ST_DUP)) |-> rsp_tdata[2])
      else $error("duplicate status without edge present");
`endif

endmodule

/* rtl/egsc_ram.sv */
module egsc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
